>>> sv/pmpd_pkg.sv
// ----------------------------------------------------------------------------
// PS/2 mouse packet decoder package
// Shared widths, byte codes, reset limits, config indices and the framing state type.
// ----------------------------------------------------------------------------
package pmpd_pkg;

    localparam int COORD_W   = 12;
    localparam int DX_W      = 9;
    localparam int DY_W      = 10;
    localparam int CFG_IDX_W = 1;

    localparam logic [7:0] ACK_BYTE = 8'hFA;
    localparam logic [7:0] HDR_MASK = 8'hC8;
    localparam logic [7:0] HDR_GOOD = 8'h08;
    localparam int         SIGN_X_BIT = 4;
    localparam int         SIGN_Y_BIT = 5;

    localparam logic [COORD_W-1:0] X_LIMIT_RST = COORD_W'(1024);
    localparam logic [COORD_W-1:0] Y_LIMIT_RST = COORD_W'(768);

    localparam logic [CFG_IDX_W-1:0] CFG_X_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_LIMIT = 1'b1;

    typedef enum logic [1:0] {
        PH_ACK = 2'd0,
        PH_HDR = 2'd1,
        PH_X   = 2'd2,
        PH_Y   = 2'd3
    } t_phase;

endpackage

>>> sv/ps2_mouse_packet_decoder_unit.sv
// ----------------------------------------------------------------------------
// PS/2 mouse packet decoder
// Frames three-byte mouse packets after the acknowledge byte and keeps a
// cursor position clamped to 0..limit on each axis.
// ----------------------------------------------------------------------------
// An accepted byte is held in the input register; the result of a packet's
// third byte is then registered in the result register.
// Throughput: one byte per cycle, limited only by the output register taking
// its result. Synchronous active-low reset clears framing to wait-for-ack,
// sets limits to 1024/768 and centers the cursor at 512/384.
module ps2_mouse_packet_decoder_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [pmpd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pmpd_pkg::COORD_W-1:0]    i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [7:0]                      i_rx_byte,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_button_left,
    output logic                            o_button_right,
    output logic                            o_button_middle,
    output logic signed [pmpd_pkg::DX_W-1:0]    o_delta_x,
    output logic signed [pmpd_pkg::DY_W-1:0]    o_delta_y,
    output logic [pmpd_pkg::COORD_W-1:0]    o_cursor_x,
    output logic [pmpd_pkg::COORD_W-1:0]    o_cursor_y,
    output logic                            o_moved
);
    import pmpd_pkg::*;

    localparam int SUM_W = COORD_W + 2;

    // pos + delta, clamped to 0..lim
    function automatic logic [COORD_W-1:0] clamp_add(
        input logic [COORD_W-1:0]     pos,
        input logic signed [DY_W-1:0] delta,
        input logic [COORD_W-1:0]     lim
    );
        logic signed [SUM_W-1:0] sum;
        sum = $signed({2'b00, pos}) + SUM_W'(delta);
        if (sum[SUM_W-1])
            return '0;
        else if (sum[SUM_W-2:0] > {1'b0, lim})
            return lim;
        else
            return sum[COORD_W-1:0];
    endfunction

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // block state
    t_phase             r_phase, n_phase;
    logic [7:0]         r_hdr, n_hdr;
    logic [7:0]         r_xbyte, n_xbyte;
    logic [COORD_W-1:0] r_x_limit, r_y_limit;
    logic [COORD_W-1:0] r_pos_x, n_pos_x;
    logic [COORD_W-1:0] r_pos_y, n_pos_y;

    // result register
    logic                     r_out_valid;
    logic [2:0]               r_buttons;
    logic signed [DX_W-1:0]   r_dx;
    logic signed [DY_W-1:0]   r_dy;
    logic [COORD_W-1:0]       r_cur_x, r_cur_y;
    logic                     r_moved;

    logic                     out_free, proc, n_emit;
    logic signed [DX_W-1:0]   dx;
    logic signed [DX_W-1:0]   dy_raw;
    logic signed [DY_W-1:0]   dy;
    logic                     moved;

    assign out_free = !r_out_valid || i_ready;
    assign proc     = r_in_valid && out_free;
    assign o_ready  = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    assign dx     = $signed({r_hdr[SIGN_X_BIT], r_xbyte});
    assign dy_raw = $signed({r_hdr[SIGN_Y_BIT], r_in_byte});
    assign dy     = -DY_W'(dy_raw);
    assign moved  = (dx != '0) || (dy_raw != '0);

    always_comb begin
        n_phase = r_phase;
        n_hdr   = r_hdr;
        n_xbyte = r_xbyte;
        n_pos_x = r_pos_x;
        n_pos_y = r_pos_y;
        n_emit  = 1'b0;
        if (proc) begin
            case (r_phase)
                PH_ACK: begin
                    if (r_in_byte == ACK_BYTE)
                        n_phase = PH_HDR;
                end
                PH_HDR: begin
                    if ((r_in_byte & HDR_MASK) == HDR_GOOD) begin
                        n_hdr   = r_in_byte;
                        n_phase = PH_X;
                    end
                end
                PH_X: begin
                    n_xbyte = r_in_byte;
                    n_phase = PH_Y;
                end
                PH_Y: begin
                    n_phase = PH_HDR;
                    n_emit  = 1'b1;
                    if (dx != '0)
                        n_pos_x = clamp_add(r_pos_x, DY_W'(dx), r_x_limit);
                    if (dy_raw != '0)
                        n_pos_y = clamp_add(r_pos_y, dy, r_y_limit);
                end
                default: n_phase = PH_ACK;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_ACK;
            r_hdr     <= '0;
            r_xbyte   <= '0;
            r_x_limit <= X_LIMIT_RST;
            r_y_limit <= Y_LIMIT_RST;
            r_pos_x   <= X_LIMIT_RST >> 1;
            r_pos_y   <= Y_LIMIT_RST >> 1;
        end else begin
            r_phase <= n_phase;
            r_hdr   <= n_hdr;
            r_xbyte <= n_xbyte;
            r_pos_x <= n_pos_x;
            r_pos_y <= n_pos_y;
            // user must write limits only while idle (not enforced here); a write re-centers that axis
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_X_LIMIT: begin
                        r_x_limit <= i_cfg_data;
                        r_pos_x   <= i_cfg_data >> 1;
                    end
                    CFG_Y_LIMIT: begin
                        r_y_limit <= i_cfg_data;
                        r_pos_y   <= i_cfg_data >> 1;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= n_emit;
        end
        if (n_emit) begin
            r_buttons <= r_hdr[2:0];
            r_dx      <= dx;
            r_dy      <= dy;
            r_cur_x   <= n_pos_x;
            r_cur_y   <= n_pos_y;
            r_moved   <= moved;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_button_left   = r_buttons[0];
    assign o_button_right  = r_buttons[1];
    assign o_button_middle = r_buttons[2];
    assign o_delta_x       = r_dx;
    assign o_delta_y       = r_dy;
    assign o_cursor_x      = r_cur_x;
    assign o_cursor_y      = r_cur_y;
    assign o_moved         = r_moved;

endmodule

>>> sv/pmpd_checker.sv
// ----------------------------------------------------------------------------
// PS/2 mouse packet decoder checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module pmpd_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_valid,
    input logic                            i_ready,
    input logic signed [pmpd_pkg::DX_W-1:0]    o_delta_x,
    input logic signed [pmpd_pkg::DY_W-1:0]    o_delta_y,
    input logic                            o_moved
);
    import pmpd_pkg::*;

    // a result is held until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped while stalled");

    // nothing valid right after reset
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_moved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_moved == ((o_delta_x != '0) || (o_delta_y != '0))))
        else $error("moved flag disagrees with deltas");

    // negated 9-bit move never reaches -256
    a_dy_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_delta_y >= -DY_W'(255)) && (o_delta_y <= DY_W'(256)))
        else $error("delta_y out of range");

endmodule

bind ps2_mouse_packet_decoder_unit pmpd_checker u_pmpd_checker (.*);
